>>> design/orb_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the output reorder buffer.
// Used by output_reorder_buffer_core; depends on nothing.
package orb_pkg;

	localparam int WINDOW_DEFAULT = 64;

	localparam logic [1:0] MODE_BEGIN  = 2'd0;
	localparam logic [1:0] MODE_FINISH = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_OUTSIDE    = 2'd1;
	localparam logic [1:0] STATUS_NOT_BEGUN  = 2'd2;

	localparam logic CFG_REORDER_ENABLE  = 1'b0;
	localparam logic CFG_FLUSH_THRESHOLD = 1'b1;

	localparam logic [6:0] THRESHOLD_RESET = 7'd8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] record_id;
		logic [31:0] record_handle;
		logic        force_req;
	} orb_item_t;

	typedef struct packed {
		logic        record_valid;
		logic [31:0] out_handle;
		logic [31:0] out_id;
		logic        last;
		logic [1:0]  status;
		logic [31:0] started_count;
		logic [31:0] finished_count;
		logic [31:0] flushed_count;
	} orb_result_t;

endpackage

>>> design/orb_record_store.sv
`timescale 1ns / 1ps
// Handle store of the output reorder buffer: one write port, one registered read port.
// Stand-alone; depends on no package.
module orb_record_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/output_reorder_buffer_core.sv
`timescale 1ns / 1ps
// A begin, a flagged event, a pass-through finish or an idle flush gives its one word
// in the cycle after it is taken. A buffered finish or a flush scans one slot per cycle,
// then emits one record word per cycle from the handle store's read port, or one status word
// if the run does not retire. Throughput: one item at a time; busy is high in scan and emit.
// Reset clears flags, window base, head slot, totals; sets default config; store not cleared.
// Result words cannot be stalled: each is shown for exactly one cycle under result_strobe.
module output_reorder_buffer_core #(
	parameter int WINDOW = orb_pkg::WINDOW_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  orb_pkg::orb_item_t  cmd,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [6:0]          cfg_wdata,
	output logic                result_strobe,
	output orb_pkg::orb_result_t result
);

	import orb_pkg::*;

	// Slot index width and run counter width (the run can cover the whole window).
	localparam int SW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [SW:0]   WIN_EXT  = (SW + 1)'(WINDOW);
	localparam logic [CW-1:0] WIN_RUN  = CW'(WINDOW);
	localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t         state_q;
	logic           enable_q;
	logic [6:0]     thr_q;
	logic [WINDOW-1:0] started_q;
	logic [WINDOW-1:0] finished_q;
	logic [31:0]    base_q;
	logic [SW-1:0]  head_q;
	logic [31:0]    started_cnt_q;
	logic [31:0]    finished_cnt_q;
	logic [31:0]    flushed_cnt_q;
	logic [CW-1:0]  run_q;
	logic           force_q;
	logic [1:0]     status_q;

	// Result stage: one word per cycle; the handle comes from the store's read register
	// unless the word is a pass-through record.
	logic           strobe_s1;
	logic           rec_s1;
	logic           pass_s1;
	logic           last_s1;
	logic [31:0]    id_s1;
	logic [31:0]    pt_handle_q;
	logic [31:0]    rd_handle;

	// Slot of a window offset, wrapped around the circular window.
	function automatic logic [SW-1:0] slot_at(input logic [SW-1:0] head,
			input logic [SW-1:0] off);
		logic [SW:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= WIN_EXT) begin
			sum = sum - WIN_EXT;
		end
		return sum[SW-1:0];
	endfunction

	logic           accept;
	logic [31:0]    off;
	logic           in_win;
	logic [SW-1:0]  item_slot;
	logic           fin_ok;
	logic [SW-1:0]  scan_slot;
	logic           scan_hit;
	logic           retire_ok;
	logic [32:0]    flushed_sum;
	logic [SW-1:0]  head_next;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign off       = cmd.record_id - base_q;
	assign in_win    = (off < 32'(WINDOW));
	assign item_slot = slot_at(head_q, off[SW-1:0]);
	// A finish that lands in the window on a started slot is stored and then scanned.
	assign fin_ok    = accept && (cmd.mode == MODE_FINISH) && enable_q && in_win
			&& started_q[item_slot];

	// The scan walks the contiguous finished run from the head, one slot per cycle.
	assign scan_slot   = slot_at(head_q, run_q[SW-1:0]);
	assign scan_hit    = (run_q < WIN_RUN) && finished_q[scan_slot];
	assign retire_ok   = force_q || (32'(run_q) >= 32'(thr_q));
	assign flushed_sum = {1'b0, flushed_cnt_q} + 33'(run_q);
	assign head_next   = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;

	orb_record_store #(
		.DEPTH (WINDOW),
		.AW    (SW)
	) u_store (
		.clk   (clk),
		.we    (fin_ok),
		.waddr (item_slot),
		.wdata (cmd.record_handle),
		.raddr (head_q),
		.rdata (rd_handle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			enable_q       <= 1'b1;
			thr_q          <= THRESHOLD_RESET;
			started_q      <= '0;
			finished_q     <= '0;
			base_q         <= '0;
			head_q         <= '0;
			started_cnt_q  <= '0;
			finished_cnt_q <= '0;
			flushed_cnt_q  <= '0;
			run_q          <= '0;
			force_q        <= 1'b0;
			status_q       <= STATUS_OK;
			strobe_s1      <= 1'b0;
			rec_s1         <= 1'b0;
			pass_s1        <= 1'b0;
			last_s1        <= 1'b0;
			id_s1          <= '0;
			pt_handle_q    <= '0;
		end else begin
			strobe_s1 <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					CFG_REORDER_ENABLE:  enable_q <= cfg_wdata[0];
					CFG_FLUSH_THRESHOLD: thr_q    <= cfg_wdata;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Default: a single status word, no record.
						status_q  <= STATUS_OK;
						rec_s1    <= 1'b0;
						pass_s1   <= 1'b0;
						last_s1   <= 1'b1;
						strobe_s1 <= 1'b1;
						case (cmd.mode)
							MODE_BEGIN: begin
								if (!(&started_cnt_q)) begin
									started_cnt_q <= started_cnt_q + 1'b1;
								end
								if (enable_q) begin
									if (!in_win) begin
										status_q <= STATUS_OUTSIDE;
									end else begin
										started_q[item_slot]  <= 1'b1;
										finished_q[item_slot] <= 1'b0;
									end
								end
							end
							MODE_FINISH: begin
								if (!(&finished_cnt_q)) begin
									finished_cnt_q <= finished_cnt_q + 1'b1;
								end
								if (!enable_q) begin
									// Pass-through: the record retires at once.
									rec_s1      <= 1'b1;
									pass_s1     <= 1'b1;
									id_s1       <= cmd.record_id;
									pt_handle_q <= cmd.record_handle;
									if (!(&flushed_cnt_q)) begin
										flushed_cnt_q <= flushed_cnt_q + 1'b1;
									end
								end else if (!in_win) begin
									status_q <= STATUS_OUTSIDE;
								end else if (!started_q[item_slot]) begin
									status_q <= STATUS_NOT_BEGUN;
								end else begin
									finished_q[item_slot] <= 1'b1;
									strobe_s1 <= 1'b0;
									run_q     <= '0;
									force_q   <= 1'b0;
									state_q   <= ST_SCAN;
								end
							end
							MODE_FLUSH: begin
								if (enable_q) begin
									strobe_s1 <= 1'b0;
									run_q     <= '0;
									force_q   <= cmd.force_req;
									state_q   <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end

				ST_SCAN: begin
					if (scan_hit) begin
						run_q <= run_q + 1'b1;
					end else if (retire_ok && (run_q != '0)) begin
						// Totals in every word are the final ones, so add the run first.
						flushed_cnt_q <= flushed_sum[32] ? '1 : flushed_sum[31:0];
						state_q       <= ST_EMIT;
					end else begin
						rec_s1    <= 1'b0;
						pass_s1   <= 1'b0;
						last_s1   <= 1'b1;
						strobe_s1 <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end

				ST_EMIT: begin
					// The store read at head_q lands in rd_handle with this word.
					strobe_s1           <= 1'b1;
					rec_s1              <= 1'b1;
					pass_s1             <= 1'b0;
					id_s1               <= base_q;
					last_s1             <= (run_q == CW'(1));
					started_q[head_q]   <= 1'b0;
					finished_q[head_q]  <= 1'b0;
					head_q              <= head_next;
					base_q              <= base_q + 1'b1;
					run_q               <= run_q - 1'b1;
					if (run_q == CW'(1)) begin
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_strobe         = strobe_s1;
	assign result.record_valid   = rec_s1;
	assign result.out_handle     = !rec_s1 ? '0 : (pass_s1 ? pt_handle_q : rd_handle);
	assign result.out_id         = rec_s1 ? id_s1 : '0;
	assign result.last           = last_s1;
	assign result.status         = status_q;
	assign result.started_count  = started_cnt_q;
	assign result.finished_count = finished_cnt_q;
	assign result.flushed_count  = flushed_cnt_q;

	// A slot is never finished without being started.
	a_fin_implies_start: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q & ~started_q) == '0)
		else $error("finished slot without started mark");

	// Every slot emitted is part of the finished run.
	a_emit_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> finished_q[head_q])
		else $error("emitting a slot that is not finished");

	// Words of one item come back to back until the last one.
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.last) |=> result_strobe)
		else $error("gap inside a retire burst");

	// A word without a record is always the only, and so the last, word.
	a_status_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.record_valid) |-> result.last)
		else $error("status word not marked last");

	// No new item is taken while words are still being emitted.
	a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.last) |-> busy)
		else $error("idle during a retire burst");

endmodule

>>> bench/output_reorder_buffer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for output_reorder_buffer_core: drives begin, finish and flush words,
// predicts the in-order retire stream and compares every result word field by field.
// Depends on orb_pkg and the core RTL only.
module output_reorder_buffer_core_tb;
	import orb_pkg::*;

	localparam int WIN = WINDOW_DEFAULT;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_WORDS = 50;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	// The mode encoding leaves one value unused; the block must answer it with a plain status word.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	orb_item_t   cmd = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_REORDER_ENABLE;
	logic [6:0]  cfg_wdata = '0;
	logic        result_strobe;
	orb_result_t result;

	output_reorder_buffer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.result_strobe(result_strobe),
		.result(result)
	);

	// Shadow copy of the buffer: configuration, slot flags, stored handles, window position
	// and the three saturating totals. It is updated once per accepted word.
	logic           reorder_on = 1'b1;
	logic [6:0]     threshold = THRESHOLD_RESET;
	logic [WIN-1:0] slot_started = '0;
	logic [WIN-1:0] slot_finished = '0;
	logic [31:0]    handle_store [WIN];
	logic [31:0]    base_id = '0;
	int             head = 0;
	logic [31:0]    started_total = '0;
	logic [31:0]    finished_total = '0;
	logic [31:0]    retired_total = '0;

	// Records retired by the word being predicted, in id order.
	logic [31:0] retired_handles [$];
	logic [31:0] retired_ids [$];

	// Result words still owed by the block, oldest first.
	orb_result_t pending_words [$];

	int errors = 0;
	int cycles = 0;
	int sent = 0;
	int max_gap = 19;

	initial begin
		forever #10 clk = ~clk;
	end

	// Watchdog. A hung handshake or a missing result word ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d result words outstanding", $time, pending_words.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] sat_add(input logic [31:0] total, input logic [31:0] n);
		return (ALL_ONES - total < n) ? ALL_ONES : total + n;
	endfunction

	// Physical slot of the id that lies off places past the window base.
	function automatic int slot_of(input logic [31:0] off);
		return (head + int'(off % WIN)) % WIN;
	endfunction

	function automatic orb_item_t make_item(input logic [1:0] mode, input logic [31:0] id,
			input logic [31:0] handle, input logic forced);
		orb_item_t it;
		it.mode = mode;
		it.record_id = id;
		it.record_handle = handle;
		it.force_req = forced;
		return it;
	endfunction

	// Counts the finished run from the head. When the request is forced, or the run is at
	// least the threshold, the whole run retires in id order and the window slides past it.
	// A threshold of zero therefore always retires, even an empty run.
	task automatic retire_run(input logic forced);
		int run;
		int s;
		int i;
		run = 0;
		while (run < WIN && slot_finished[slot_of(run)])
			run++;
		if (!forced && run < int'(threshold))
			return;
		for (i = 0; i < run; i++) begin
			s = slot_of(i);
			retired_handles.push_back(handle_store[s]);
			retired_ids.push_back(base_id + i);
			slot_started[s] = 1'b0;
			slot_finished[s] = 1'b0;
		end
		base_id += run;
		head = slot_of(run);
		retired_total = sat_add(retired_total, run);
	endtask

	// Applies one accepted word to the shadow state and queues the result words it owes.
	task automatic predict_words(input orb_item_t it);
		logic [31:0] off;
		logic [1:0]  st;
		orb_result_t w;
		int n;
		int k;
		retired_handles.delete();
		retired_ids.delete();
		st = STATUS_OK;
		// Distance into the window, modulo 2^32, so ids below the base land far outside.
		off = it.record_id - base_id;
		case (it.mode)
			MODE_BEGIN: begin
				started_total = sat_add(started_total, 1);
				if (reorder_on) begin
					if (off >= WIN) begin
						st = STATUS_OUTSIDE;
					end else begin
						// A repeated begin also clears an earlier finished mark.
						slot_started[slot_of(off)] = 1'b1;
						slot_finished[slot_of(off)] = 1'b0;
					end
				end
			end
			MODE_FINISH: begin
				finished_total = sat_add(finished_total, 1);
				if (!reorder_on) begin
					// Pass-through: the record leaves at once under its own id.
					retired_handles.push_back(it.record_handle);
					retired_ids.push_back(it.record_id);
					retired_total = sat_add(retired_total, 1);
				end else if (off >= WIN) begin
					st = STATUS_OUTSIDE;
				end else if (!slot_started[slot_of(off)]) begin
					st = STATUS_NOT_BEGUN;
				end else begin
					handle_store[slot_of(off)] = it.record_handle;
					slot_finished[slot_of(off)] = 1'b1;
					retire_run(1'b0);
				end
			end
			MODE_FLUSH: begin
				if (reorder_on)
					retire_run(it.force_req);
			end
			default: begin
			end
		endcase
		// A word that retires nothing still answers with one status word.
		n = (retired_ids.size() == 0) ? 1 : retired_ids.size();
		for (k = 0; k < n; k++) begin
			w = '0;
			w.record_valid = retired_ids.size() != 0;
			if (w.record_valid) begin
				w.out_handle = retired_handles[k];
				w.out_id = retired_ids[k];
			end
			w.last = (k == n - 1);
			w.status = st;
			w.started_count = started_total;
			w.finished_count = finished_total;
			w.flushed_count = retired_total;
			pending_words.push_back(w);
		end
	endtask

	// The sender waits a random number of cycles, then holds start until the block takes the
	// word. Start is left high on return so that a zero gap gives back-to-back words.
	task automatic send_word(input orb_item_t it);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= it;
		do
			@(posedge clk);
		while (busy);
		predict_words(it);
		sent++;
	endtask

	// Stops sending and waits until every owed result word has come, plus a short margin
	// so that the block is idle before any register write.
	task automatic drain();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only called while the block is idle. The shadow copy keeps what the register holds.
	task automatic write_reg(input logic idx, input logic [6:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_REORDER_ENABLE)
			reorder_on = value[0];
		else
			threshold = value;
	endtask

	// Begins n consecutive ids from the current base, then finishes them in shuffled order
	// with random handles, and sometimes ends with a flush request.
	task automatic run_sequence(input int n);
		logic [31:0] first;
		int order [$];
		int i;
		int j;
		int tmp;
		first = base_id;
		for (i = 0; i < n; i++) begin
			send_word(make_item(MODE_BEGIN, first + i, $urandom, $urandom_range(0, 1)));
			order.push_back(i);
		end
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (i = 0; i < n; i++)
			send_word(make_item(MODE_FINISH, first + order[i], $urandom, $urandom_range(0, 1)));
		if ($urandom_range(0, 2) == 0)
			send_word(make_item(MODE_FLUSH, $urandom, $urandom, $urandom_range(0, 1)));
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Each result word is taken at the edge that ends its strobe cycle and matched against
	// the oldest owed word.
	always @(posedge clk) begin : check_words
		orb_result_t want;
		if (arst_n && result_strobe) begin
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got id %h handle %h last %b",
					$time, result.out_id, result.out_handle, result.last);
			end else begin
				want = pending_words.pop_front();
				check_field("record_valid", want.record_valid, result.record_valid);
				check_field("out_handle", want.out_handle, result.out_handle);
				check_field("out_id", want.out_id, result.out_id);
				check_field("last", want.last, result.last);
				check_field("status", want.status, result.status);
				check_field("started_count", want.started_count, result.started_count);
				check_field("finished_count", want.finished_count, result.finished_count);
				check_field("flushed_count", want.flushed_count, result.flushed_count);
			end
		end
	end

	// Reset configuration: unused mode, empty flushes, flagged events, a small out-of-order
	// batch with a forced flush, repeated begin and finish, and the top slot of the window.
	task automatic test_directed();
		send_word(make_item(MODE_UNUSED, ALL_ONES, ALL_ONES, 1'b1));
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b0));
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b1));
		send_word(make_item(MODE_FINISH, 32'd5, 32'hA5A5_A5A5, 1'b0));
		send_word(make_item(MODE_BEGIN, WIN, '0, 1'b0));
		send_word(make_item(MODE_BEGIN, ALL_ONES, ALL_ONES, 1'b0));
		send_word(make_item(MODE_FINISH, 32'd1000, 32'h1, 1'b0));
		send_word(make_item(MODE_BEGIN, 32'd0, '0, 1'b0));
		send_word(make_item(MODE_BEGIN, 32'd1, '0, 1'b0));
		send_word(make_item(MODE_BEGIN, 32'd2, '0, 1'b0));
		send_word(make_item(MODE_BEGIN, 32'd3, '0, 1'b0));
		send_word(make_item(MODE_FINISH, 32'd2, '0, 1'b0));
		send_word(make_item(MODE_FINISH, 32'd0, ALL_ONES, 1'b0));
		send_word(make_item(MODE_FINISH, 32'd1, 32'h1234_5678, 1'b0));
		// Three finished records sit below the threshold until the forced flush.
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b1));
		// Id 3 is begun again, finished twice (the second handle wins), then begun again,
		// which drops the finished mark, and finished a third time.
		send_word(make_item(MODE_BEGIN, 32'd3, '0, 1'b0));
		send_word(make_item(MODE_FINISH, 32'd3, 32'h0BAD_F00D, 1'b0));
		send_word(make_item(MODE_FINISH, 32'd3, 32'hCAFE_0001, 1'b0));
		send_word(make_item(MODE_BEGIN, 32'd3, '0, 1'b0));
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b1));
		send_word(make_item(MODE_FINISH, 32'd3, 32'hCAFE_0002, 1'b0));
		// The last slot of the window is still inside it.
		send_word(make_item(MODE_BEGIN, 32'd3 + WIN - 1, '0, 1'b0));
		send_word(make_item(MODE_FINISH, 32'd3 + WIN - 1, 32'h7777_8888, 1'b0));
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b0));
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b1));
	endtask

	// Threshold extremes: one retires on every in-order finish, zero retires on any flush,
	// the full window retires as one 64-word burst, and the largest value never triggers.
	task automatic test_threshold();
		drain();
		write_reg(CFG_FLUSH_THRESHOLD, 7'd1);
		send_word(make_item(MODE_BEGIN, base_id, '0, 1'b0));
		send_word(make_item(MODE_FINISH, base_id, $urandom, 1'b0));
		run_sequence(4);
		drain();
		write_reg(CFG_FLUSH_THRESHOLD, 7'd0);
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b0));
		run_sequence(3);
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b0));
		drain();
		// No idle cycles on the sender side through the full-window burst.
		write_reg(CFG_FLUSH_THRESHOLD, WIN);
		max_gap = 0;
		run_sequence(WIN);
		drain();
		max_gap = 19;
		write_reg(CFG_FLUSH_THRESHOLD, 7'h7F);
		run_sequence(10);
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b0));
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b1));
	endtask

	// With reordering off, finishes pass straight through and flushes do nothing. Records
	// buffered before the switch must still be there once reordering is back on.
	task automatic test_passthrough();
		logic [31:0] first;
		int i;
		drain();
		first = base_id;
		send_word(make_item(MODE_BEGIN, first, '0, 1'b0));
		send_word(make_item(MODE_BEGIN, first + 1, '0, 1'b0));
		send_word(make_item(MODE_FINISH, first + 1, 32'h5555_AAAA, 1'b0));
		drain();
		// Only bit 0 of the write data matters for this register.
		write_reg(CFG_REORDER_ENABLE, 7'h7E);
		send_word(make_item(MODE_BEGIN, $urandom, '0, 1'b1));
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b1));
		send_word(make_item(MODE_FINISH, first, 32'h1357_9BDF, 1'b0));
		send_word(make_item(MODE_FINISH, ALL_ONES, ALL_ONES, 1'b1));
		send_word(make_item(MODE_FINISH, '0, '0, 1'b0));
		for (i = 0; i < 4; i++)
			send_word(make_item(MODE_FINISH, $urandom, $urandom, $urandom_range(0, 1)));
		drain();
		write_reg(CFG_REORDER_ENABLE, 7'h01);
		send_word(make_item(MODE_FINISH, first, 32'h2468_ACE0, 1'b0));
		send_word(make_item(MODE_FLUSH, '0, '0, 1'b1));
	endtask

	// Random phases, each with its own settings. Most traffic is well-formed begin/finish
	// batches; the rest is noise: stray ids, finishes without begin, unused modes, flushes.
	task automatic test_random();
		int first_sent;
		int phase_end;
		int pick;
		logic [31:0] id;
		first_sent = sent;
		while (sent - first_sent < RANDOM_WORDS) begin
			drain();
			write_reg(CFG_REORDER_ENABLE, {$urandom_range(0, 63), $urandom_range(0, 7) != 0});
			case ($urandom_range(0, 7))
				0: write_reg(CFG_FLUSH_THRESHOLD, 7'd0);
				1: write_reg(CFG_FLUSH_THRESHOLD, 7'd1);
				2: write_reg(CFG_FLUSH_THRESHOLD, WIN);
				3: write_reg(CFG_FLUSH_THRESHOLD, 7'h7F);
				default: write_reg(CFG_FLUSH_THRESHOLD, $urandom_range(2, 10));
			endcase
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
			phase_end = sent + 25;
			while (sent < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					run_sequence(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
						: $urandom_range(1, 12));
				end else begin
					id = ($urandom_range(0, 1) != 0) ? base_id + $urandom_range(0, WIN + 8)
						: $urandom;
					send_word(make_item($urandom_range(0, 3), id, $urandom, $urandom_range(0, 1)));
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold();
		test_passthrough();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
